>>> sv/truncated_gaussian_polar_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the truncated Gaussian polar core
// Clocked property checks, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef TRUNCATED_GAUSSIAN_POLAR_CORE_ASSERT_SVH
`define TRUNCATED_GAUSSIAN_POLAR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check that is off while reset is asserted
`define TGP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tgp assertion failed");
// check that also holds during reset
`define TGP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tgp reset assertion failed");
`else
`define TGP_ASSERT(lbl, clk, rst_n, prop)
`define TGP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> sv/tgp_pkg.sv
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared constants and codes of the truncated Gaussian polar core.
// ----------------------------------------------------------------------------
`default_nettype none

package tgp_pkg;

    localparam int UNIFORM_WIDTH_DEF = 16;
    localparam int LOG_FRAC_BITS     = 24;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;

    localparam int XM_MAX            = 32767;

    localparam logic signed [15:0] MEAN_RST  = 16'sd0;
    localparam logic [15:0]        STD_RST   = 16'd256;
    localparam logic [14:0]        LIMIT_RST = 15'd32767;

    typedef enum logic [1:0] {
        REG_MEAN        = 2'd0,
        REG_STD_DEV     = 2'd1,
        REG_TRUNC_LIMIT = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

>>> sv/tgp_log2.sv
// ----------------------------------------------------------------------------
// tgp_log2
// Pipelined fractional log2 of a Q1.31 mantissa, one squaring per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_log2 import tgp_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [31:0]              i_y,
    input  wire logic [SIDE_W-1:0]        i_side,
    output logic                          o_valid,
    output logic [LOG_FRAC_BITS-1:0]      o_f,
    output logic [SIDE_W-1:0]             o_side
);

    logic [LOG_FRAC_BITS-1:0] r_v;
    logic [31:0]              r_y    [LOG_FRAC_BITS];
    logic [LOG_FRAC_BITS-1:0] r_f    [LOG_FRAC_BITS];
    logic [SIDE_W-1:0]        r_side [LOG_FRAC_BITS];

    for (genvar j = 0; j < LOG_FRAC_BITS; j++) begin : g_stg
        logic                     v_in;
        logic [31:0]              y_in;
        logic [LOG_FRAC_BITS-1:0] f_in;
        logic [SIDE_W-1:0]        side_in;
        logic [63:0]              sq;
        logic [32:0]              yn;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign y_in    = i_y;
            assign f_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign y_in    = r_y[j-1];
            assign f_in    = r_f[j-1];
            assign side_in = r_side[j-1];
        end

        assign sq = 64'(y_in) * 64'(y_in);
        assign yn = sq[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[j]    <= yn[32] ? yn[32:1] : yn[31:0];
                r_f[j]    <= {f_in[LOG_FRAC_BITS-2:0], yn[32]};
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_v[LOG_FRAC_BITS-1];
    assign o_f     = r_f[LOG_FRAC_BITS-1];
    assign o_side  = r_side[LOG_FRAC_BITS-1];

endmodule

`default_nettype wire

>>> sv/tgp_div.sv
// ----------------------------------------------------------------------------
// tgp_div
// Pipelined restoring divider: (n << 30) / d, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_div import tgp_pkg::*; #(
    parameter int N_W    = 30,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [N_W-1:0]    i_n,
    input  wire logic [31:0]       i_d,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [N_W-1:0]         o_q,
    output logic [SIDE_W-1:0]      o_side
);

    // divisor is at least 2^30, so the quotient fits N_W bits
    localparam int R_W = N_W + 32;

    logic [N_W-1:0]    r_v;
    logic [R_W-1:0]    r_rem  [N_W];
    logic [N_W-1:0]    r_q    [N_W];
    logic [31:0]       r_d    [N_W];
    logic [SIDE_W-1:0] r_side [N_W];

    for (genvar j = 0; j < N_W; j++) begin : g_stg
        localparam int K = N_W - 1 - j;
        logic              v_in;
        logic [R_W-1:0]    rem_in;
        logic [N_W-1:0]    q_in;
        logic [31:0]       d_in;
        logic [SIDE_W-1:0] side_in;
        logic [R_W-1:0]    t;
        logic              ge;
        logic [N_W-1:0]    n_q;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = {2'b00, i_n, 30'd0};
            assign q_in    = '0;
            assign d_in    = i_d;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign rem_in  = r_rem[j-1];
            assign q_in    = r_q[j-1];
            assign d_in    = r_d[j-1];
            assign side_in = r_side[j-1];
        end

        assign t  = R_W'(d_in) << K;
        assign ge = rem_in >= t;

        always_comb begin
            n_q    = q_in;
            n_q[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? rem_in - t : rem_in;
                r_q[j]    <= n_q;
                r_d[j]    <= d_in;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_v[N_W-1];
    assign o_q     = r_q[N_W-1];
    assign o_side  = r_side[N_W-1];

endmodule

`default_nettype wire

>>> sv/tgp_sqrt.sv
// ----------------------------------------------------------------------------
// tgp_sqrt
// Pipelined floor square root of g << 24, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_sqrt import tgp_pkg::*; #(
    parameter int G_W    = 30,
    parameter int SIDE_W = 8,
    localparam int H_W   = (G_W + 25) / 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [G_W-1:0]    i_g,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [H_W-1:0]         o_h,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int T_W = 2 * H_W + 2;

    logic [H_W-1:0]    r_v;
    logic [T_W-1:0]    r_rem  [H_W];
    logic [H_W-1:0]    r_r    [H_W];
    logic [SIDE_W-1:0] r_side [H_W];

    for (genvar j = 0; j < H_W; j++) begin : g_stg
        localparam int B = H_W - 1 - j;
        logic              v_in;
        logic [T_W-1:0]    rem_in;
        logic [H_W-1:0]    r_in;
        logic [SIDE_W-1:0] side_in;
        logic [T_W-1:0]    t;
        logic              ge;
        logic [H_W-1:0]    n_r;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = T_W'({i_g, 24'd0});
            assign r_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign rem_in  = r_rem[j-1];
            assign r_in    = r_r[j-1];
            assign side_in = r_side[j-1];
        end

        // (r + 2^B)^2 - r^2
        assign t  = (T_W'(r_in) << (B + 1)) + (T_W'(1) << (2 * B));
        assign ge = rem_in >= t;

        always_comb begin
            n_r    = r_in;
            n_r[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? rem_in - t : rem_in;
                r_r[j]    <= n_r;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_v[H_W-1];
    assign o_h     = r_r[H_W-1];
    assign o_side  = r_side[H_W-1];

endmodule

`default_nettype wire

>>> sv/truncated_gaussian_polar_core.sv
// ----------------------------------------------------------------------------
// truncated_gaussian_polar_core
// Marsaglia polar Gaussian sampler with scaling and truncation, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid/o_ready) takes one item per cycle while o_ready is
//    high: a pair of uniform draws u1, u2 in signed Q1.15.
//  - Output channel (o_valid/i_ready) gives 0, 1 or 2 result items per input
//    item: the u1 sample first, then the u2 sample; o_last marks the final one.
//  - Rejected pairs (w = 0 or w >= 1) and samples beyond trunc_limit give no
//    result item.
//  - Config channel (i_cfg_valid/o_cfg_ready) is always ready; write it only
//    while the block is idle. Index 0 mean, 1 std_dev, 2 trunc_limit.
//  - Each item passes through the log2, divide and square root pipelines.
//  - Throughput: one item per cycle while at most one result per item comes
//    out and i_ready is high; an item with two results holds the pipeline
//    while its u1 result is sent, as the output register sends one result
//    item per cycle.
//  - When the receiver stalls, the whole pipeline holds; nothing is lost.
//  - Synchronous reset clears all valid bits and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module truncated_gaussian_polar_core import tgp_pkg::*; #(
    parameter int UNIFORM_WIDTH = UNIFORM_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input items
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [UNIFORM_WIDTH-1:0] i_u1_draw,
    input  wire logic [UNIFORM_WIDTH-1:0] i_u2_draw,
    // result items
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [15:0]                   o_sample,
    output logic                          o_from_second,
    output logic                          o_last,
    // configuration writes
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [15:0]              i_cfg_data
);

`include "truncated_gaussian_polar_core_assert.svh"

    localparam int FB    = UNIFORM_WIDTH - 1;
    localparam int MAG_W = UNIFORM_WIDTH;
    localparam int W_W   = 2 * UNIFORM_WIDTH;
    localparam int S_MAX = 2 * FB;
    localparam int P_W   = $clog2(S_MAX);
    localparam int S_W   = $clog2(S_MAX + 1);
    localparam int L_W   = S_W + LOG_FRAC_BITS;
    localparam int N_W   = L_W + 1;            // n24 < 2 * l24
    localparam int Q_W   = N_W;
    localparam int H_W   = (Q_W + 25) / 2;
    localparam int PX_W  = MAG_W + H_W;
    localparam int SH_W  = $clog2(FB + 13);

    typedef struct packed {
        logic [31:0]      mq;
        logic [S_W-1:0]   s;
        logic [MAG_W-1:0] mag0;
        logic [MAG_W-1:0] mag1;
        logic             neg0;
        logic             neg1;
    } t_lside;

    typedef struct packed {
        logic [S_W-1:0]   s2;
        logic [MAG_W-1:0] mag0;
        logic [MAG_W-1:0] mag1;
        logic             neg0;
        logic             neg1;
    } t_dside;

    // ---------------- configuration registers ----------------
    logic signed [15:0] r_mean;
    logic [15:0]        r_std;
    logic [14:0]        r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= MEAN_RST;
            r_std   <= STD_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MEAN:        r_mean  <= $signed(i_cfg_data);
                REG_STD_DEV:     r_std   <= i_cfg_data;
                REG_TRUNC_LIMIT: r_limit <= i_cfg_data[14:0];
                default:         ;   // unknown index: ignored
            endcase
        end
    end

    // ---------------- global advance ----------------
    // Whole pipeline moves together; it stops while the output register holds
    // a result the receiver does not take this cycle, or holds both of a pair.
    logic [1:0] r_pend;
    logic       w_en;

    assign w_en    = (r_pend == 2'b00) || (i_ready && (r_pend != 2'b11));
    assign o_ready = w_en;

    // ---------------- S1: sign and magnitude ----------------
    logic             r_s1_v;
    logic [MAG_W-1:0] r_s1_mag0, r_s1_mag1;
    logic             r_s1_neg0, r_s1_neg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_neg0 <= i_u1_draw[FB];
            r_s1_neg1 <= i_u2_draw[FB];
            r_s1_mag0 <= i_u1_draw[FB] ? (~i_u1_draw + MAG_W'(1)) : i_u1_draw;
            r_s1_mag1 <= i_u2_draw[FB] ? (~i_u2_draw + MAG_W'(1)) : i_u2_draw;
        end
    end

    // ---------------- S2: w = u1^2 + u2^2 ----------------
    logic             r_s2_v;
    logic [W_W-1:0]   r_s2_w;
    logic [MAG_W-1:0] r_s2_mag0, r_s2_mag1;
    logic             r_s2_neg0, r_s2_neg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_w    <= W_W'(r_s1_mag0) * W_W'(r_s1_mag0)
                       + W_W'(r_s1_mag1) * W_W'(r_s1_mag1);
            r_s2_mag0 <= r_s1_mag0;
            r_s2_mag1 <= r_s1_mag1;
            r_s2_neg0 <= r_s1_neg0;
            r_s2_neg1 <= r_s1_neg1;
        end
    end

    // ---------------- S3: reject test, leading one ----------------
    logic             r_s3_v;
    logic [W_W-1:0]   r_s3_w;
    logic [P_W-1:0]   r_s3_p;
    logic [MAG_W-1:0] r_s3_mag0, r_s3_mag1;
    logic             r_s3_neg0, r_s3_neg1;
    logic             w_ok;
    logic [P_W-1:0]   w_p;

    // accepted only for 0 < w < 1.0 (bit 2*FB and above clear)
    assign w_ok = (r_s2_w != '0) && (r_s2_w[W_W-1:S_MAX] == '0);

    always_comb begin
        w_p = '0;
        for (int b = 0; b < S_MAX; b++) begin
            if (r_s2_w[b]) begin
                w_p = P_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s3_v <= r_s2_v && w_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_w    <= r_s2_w;
            r_s3_p    <= w_p;
            r_s3_mag0 <= r_s2_mag0;
            r_s3_mag1 <= r_s2_mag1;
            r_s3_neg0 <= r_s2_neg0;
            r_s3_neg1 <= r_s2_neg1;
        end
    end

    // ---------------- S4: normalize to Q1.31 mantissa ----------------
    logic        r_s4_v;
    t_lside      r_s4_side;
    logic [63:0] w_norm;
    logic [5:0]  w_lz;

    assign w_lz   = 6'(63 - int'(r_s3_p));
    assign w_norm = 64'(r_s3_w) << w_lz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (w_en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_side.mq   <= w_norm[63:32];
            r_s4_side.s    <= S_W'(S_MAX - int'(r_s3_p));
            r_s4_side.mag0 <= r_s3_mag0;
            r_s4_side.mag1 <= r_s3_mag1;
            r_s4_side.neg0 <= r_s3_neg0;
            r_s4_side.neg1 <= r_s3_neg1;
        end
    end

    // ---------------- log2 pipeline ----------------
    logic                     w_lg_v;
    logic [LOG_FRAC_BITS-1:0] w_lg_f;
    logic [$bits(t_lside)-1:0] w_lg_side_bits;
    t_lside                   w_lg_side;

    tgp_log2 #(
        .SIDE_W ($bits(t_lside))
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s4_v),
        .i_y     (r_s4_side.mq),
        .i_side  (r_s4_side),
        .o_valid (w_lg_v),
        .o_f     (w_lg_f),
        .o_side  (w_lg_side_bits)
    );

    assign w_lg_side = t_lside'(w_lg_side_bits);

    // ---------------- S5: n = -2 ln w, divisor select ----------------
    logic             r_s5_v;
    logic [N_W-1:0]   r_s5_n;
    logic [31:0]      r_s5_d;
    t_dside           r_s5_side;
    logic [L_W-1:0]   w_l24;
    logic [L_W+32:0]  w_nprod;

    assign w_l24   = {w_lg_side.s, LOG_FRAC_BITS'(0)} - L_W'(w_lg_f);
    assign w_nprod = (L_W+33)'(w_l24) * (L_W+33)'(LN2_Q32) + ((L_W+33)'(1) << 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (w_en) begin
            r_s5_v <= w_lg_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_n <= w_nprod[31 +: N_W];
            // odd exponent: keep mantissa, round exponent up to even
            if (w_lg_side.s[0]) begin
                r_s5_d         <= w_lg_side.mq;
                r_s5_side.s2   <= w_lg_side.s + S_W'(1);
            end else begin
                r_s5_d         <= {1'b0, w_lg_side.mq[31:1]};
                r_s5_side.s2   <= w_lg_side.s;
            end
            r_s5_side.mag0 <= w_lg_side.mag0;
            r_s5_side.mag1 <= w_lg_side.mag1;
            r_s5_side.neg0 <= w_lg_side.neg0;
            r_s5_side.neg1 <= w_lg_side.neg1;
        end
    end

    // ---------------- divide and square root pipelines ----------------
    logic                      w_dv_v;
    logic [Q_W-1:0]            w_dv_q;
    logic [$bits(t_dside)-1:0] w_dv_side;
    logic                      w_sq_v;
    logic [H_W-1:0]            w_sq_h;
    logic [$bits(t_dside)-1:0] w_sq_side_bits;
    t_dside                    w_sq_side;

    tgp_div #(
        .N_W    (N_W),
        .SIDE_W ($bits(t_dside))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s5_v),
        .i_n     (r_s5_n),
        .i_d     (r_s5_d),
        .i_side  (r_s5_side),
        .o_valid (w_dv_v),
        .o_q     (w_dv_q),
        .o_side  (w_dv_side)
    );

    tgp_sqrt #(
        .G_W    (Q_W),
        .SIDE_W ($bits(t_dside))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_v),
        .i_g     (w_dv_q),
        .i_side  (w_dv_side),
        .o_valid (w_sq_v),
        .o_h     (w_sq_h),
        .o_side  (w_sq_side_bits)
    );

    assign w_sq_side = t_dside'(w_sq_side_bits);

    // ---------------- X1: |u| * h ----------------
    logic            r_x1_v;
    logic [PX_W-1:0] r_x1_p0, r_x1_p1;
    logic [SH_W-1:0] r_x1_sh;
    logic            r_x1_neg0, r_x1_neg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v <= 1'b0;
        end else if (w_en) begin
            r_x1_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1_p0   <= PX_W'(w_sq_side.mag0) * PX_W'(w_sq_h);
            r_x1_p1   <= PX_W'(w_sq_side.mag1) * PX_W'(w_sq_h);
            r_x1_sh   <= SH_W'(FB + 12 - int'(w_sq_side.s2 >> 1));
            r_x1_neg0 <= w_sq_side.neg0;
            r_x1_neg1 <= w_sq_side.neg1;
        end
    end

    // ---------------- X2: round to Q4.12, saturate ----------------
    logic            r_x2_v;
    logic [14:0]     r_x2_xm0, r_x2_xm1;
    logic            r_x2_neg0, r_x2_neg1;
    logic [PX_W:0]   w_rnd, w_sft0, w_sft1;

    assign w_rnd  = (PX_W+1)'(1) << (r_x1_sh - SH_W'(1));
    assign w_sft0 = ((PX_W+1)'(r_x1_p0) + w_rnd) >> r_x1_sh;
    assign w_sft1 = ((PX_W+1)'(r_x1_p1) + w_rnd) >> r_x1_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x2_v <= 1'b0;
        end else if (w_en) begin
            r_x2_v <= r_x1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x2_xm0  <= (w_sft0 > (PX_W+1)'(XM_MAX)) ? 15'(XM_MAX) : w_sft0[14:0];
            r_x2_xm1  <= (w_sft1 > (PX_W+1)'(XM_MAX)) ? 15'(XM_MAX) : w_sft1[14:0];
            r_x2_neg0 <= r_x1_neg0;
            r_x2_neg1 <= r_x1_neg1;
        end
    end

    // ---------------- X3: std_dev * x ----------------
    logic        r_x3_v;
    logic [30:0] r_x3_sp0, r_x3_sp1;
    logic        r_x3_neg0, r_x3_neg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x3_v <= 1'b0;
        end else if (w_en) begin
            r_x3_v <= r_x2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x3_sp0  <= 31'(r_std) * 31'(r_x2_xm0);
            r_x3_sp1  <= 31'(r_std) * 31'(r_x2_xm1);
            r_x3_neg0 <= r_x2_neg0;
            r_x3_neg1 <= r_x2_neg1;
        end
    end

    // ---------------- X4: add mean, saturate, truncate ----------------
    logic [15:0] w_smp  [2];
    logic [1:0]  w_keep;

    for (genvar k = 0; k < 2; k++) begin : g_fin
        logic [31:0]        sp;
        logic [19:0]        pm;
        logic signed [21:0] mean_x, pm_x, vs;
        logic [16:0]        ext, av;

        assign sp     = (k == 0) ? 32'(r_x3_sp0) : 32'(r_x3_sp1);
        assign pm     = 20'((sp + 32'd2048) >> 12);
        assign mean_x = 22'(r_mean);
        assign pm_x   = $signed({2'b00, pm});
        assign vs     = ((k == 0) ? r_x3_neg0 : r_x3_neg1) ? mean_x - pm_x : mean_x + pm_x;

        always_comb begin
            if (vs > 22'sd32767) begin
                w_smp[k] = 16'h7fff;
            end else if (vs < -22'sd32768) begin
                w_smp[k] = 16'h8000;
            end else begin
                w_smp[k] = vs[15:0];
            end
        end

        assign ext       = {w_smp[k][15], w_smp[k]};
        assign av        = w_smp[k][15] ? (~ext + 17'd1) : ext;
        assign w_keep[k] = r_x3_v && (av <= {2'b00, r_limit});
    end

    // ---------------- output register ----------------
    // r_pend[0]: u1 result waiting, r_pend[1]: u2 result waiting
    logic [15:0] r_smp0, r_smp1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'b00;
        end else if (w_en) begin
            r_pend <= w_keep;
        end else if (i_ready) begin
            r_pend[0] <= 1'b0;   // u1 sent, u2 still waits
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_smp0 <= w_smp[0];
            r_smp1 <= w_smp[1];
        end
    end

    assign o_valid       = r_pend != 2'b00;
    assign o_sample      = r_pend[0] ? r_smp0 : r_smp1;
    assign o_from_second = !r_pend[0];
    assign o_last        = r_pend != 2'b11;

    // ---------------- assertions ----------------
    `TGP_ASSERT(a_stall_holds, i_clk, i_rst_n, !w_en |=> $stable(r_x3_v))
    `TGP_ASSERT(a_second_is_last, i_clk, i_rst_n, (o_valid && o_from_second) |-> o_last)
    `TGP_ASSERT(a_pair_back_to_back, i_clk, i_rst_n,
        (o_valid && i_ready && !o_last) |=> (o_valid && o_from_second))
    `TGP_ASSERT(a_no_accept_while_pair, i_clk, i_rst_n, (r_pend == 2'b11) |-> !o_ready)
    `TGP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

`default_nettype wire
